FILE: hdl/rwr_pkg.sv
// rwr_pkg: types, widths and codes shared by the rolling window regression block
// no dependencies; imported by every module of the block except rwr_ram
`default_nettype none

package rwr_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int RESULT_W   = 48;
    localparam int RING_W     = SAMPLE_W + 1;
    localparam int CNT_W      = 9;
    localparam int SX_W       = 19;
    localparam int SX2_W      = 28;
    localparam int SY_W       = 33;
    localparam int SY2_W      = 56;
    localparam int SXY_W      = 42;
    localparam int OPND_W     = 72;
    localparam int WIDE_W     = 128;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 2'd2;

    localparam logic [1:0] MODE_MEAN  = 2'd0;
    localparam logic [1:0] MODE_SLOPE = 2'd1;
    localparam logic [1:0] MODE_RSQ   = 2'd2;
    localparam logic [1:0] MODE_RESI  = 2'd3;

    localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       missing;
        logic                       series_start;
    } t_in;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic                       defined;
    } t_out;

    typedef struct packed {
        logic        [CNT_W-1:0] n;
        logic signed [SX_W-1:0]  sx;
        logic signed [SX2_W-1:0] sx2;
        logic signed [SY_W-1:0]  sy;
        logic signed [SY2_W-1:0] sy2;
        logic signed [SXY_W-1:0] sxy;
    } t_sums;

endpackage

`default_nettype wire

FILE: hdl/rwr_ram.sv
// rwr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rwr_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rwr_acc.sv
// rwr_acc: sweeps the sample ring newest first and accumulates the window sums
// depends on rwr_pkg; reads the ring through rwr_ram
`default_nettype none

module rwr_acc #(
    parameter int DEPTH = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rwr_pkg::CNT_W-1:0]    i_count,
    input  wire logic [rwr_pkg::CNT_W-1:0]    i_w,
    input  wire logic [$clog2(DEPTH)-1:0]     i_last,
    output logic                              o_rd_en,
    output logic      [$clog2(DEPTH)-1:0]     o_rd_addr,
    input  wire logic [rwr_pkg::RING_W-1:0]   i_rd_data,
    output rwr_pkg::t_sums                    o_sums,
    output logic                              o_done
);
    import rwr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_k;
    logic [AW-1:0]                 r_addr;
    logic [CNT_W-1:0]              r_x;
    logic                          r_v1;
    logic [CNT_W-1:0]              r_x1;
    logic                          r_v2;
    logic [2*CNT_W-1:0]            r_pxx;
    logic signed [2*SAMPLE_W-1:0]  r_pyy;
    logic signed [CNT_W+SAMPLE_W:0] r_pxy;
    logic signed [SAMPLE_W-1:0]    r_py;
    logic [CNT_W-1:0]              r_px;
    t_sums                         r_sums;
    logic                          r_done;

    logic                          issue;
    logic signed [SAMPLE_W-1:0]    rd_y;
    logic                          rd_miss;

    assign issue     = r_busy && (r_k != i_count);
    assign o_rd_en   = issue;
    assign o_rd_addr = r_addr;
    assign rd_y      = $signed(i_rd_data[SAMPLE_W-1:0]);
    assign rd_miss   = i_rd_data[SAMPLE_W];
    assign o_sums    = r_sums;
    assign o_done    = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= issue;
            r_v2   <= r_v1 && !rd_miss;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_addr <= i_last;
                r_x    <= i_w;
                r_sums <= '0;
            end else if (issue) begin
                r_k    <= r_k + 1'b1;
                r_addr <= (r_addr == '0) ? TOP_ADDR : r_addr - 1'b1;
                r_x    <= r_x - 1'b1;
                r_x1   <= r_x;
            end else if (r_busy && !r_v1 && !r_v2) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            // product stage
            if (r_v1) begin
                r_pxx <= (2*CNT_W)'(r_x1) * (2*CNT_W)'(r_x1);
                r_pyy <= rd_y * rd_y;
                r_pxy <= $signed({1'b0, r_x1}) * rd_y;
                r_py  <= rd_y;
                r_px  <= r_x1;
            end
            // accumulate stage
            if (r_v2) begin
                r_sums.n   <= r_sums.n + 1'b1;
                r_sums.sx  <= r_sums.sx + SX_W'(r_px);
                r_sums.sx2 <= r_sums.sx2 + SX2_W'(r_pxx);
                r_sums.sy  <= r_sums.sy + SY_W'(r_py);
                r_sums.sy2 <= r_sums.sy2 + SY2_W'(r_pyy);
                r_sums.sxy <= r_sums.sxy + SXY_W'(r_pxy);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rwr_mul.sv
// rwr_mul: shared signed multiplier, one 4-bit digit of the second operand a cycle
// depends on rwr_pkg
`default_nettype none

module rwr_mul (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [rwr_pkg::OPND_W-1:0] i_a,
    input  wire logic signed [rwr_pkg::OPND_W-1:0] i_b,
    output logic signed      [rwr_pkg::WIDE_W-1:0] o_prod,
    output logic                                   o_done
);
    import rwr_pkg::*;

    localparam int STEPS = OPND_W / DIGIT_W;
    localparam int CW    = $clog2(STEPS);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic                r_neg;
    logic [WIDE_W-1:0]   r_mc;
    logic [OPND_W-1:0]   r_mp;
    logic [WIDE_W-1:0]   r_acc;

    logic [OPND_W-1:0]   mag_a;
    logic [OPND_W-1:0]   mag_b;

    assign mag_a  = i_a[OPND_W-1] ? OPND_W'(-i_a) : OPND_W'(i_a);
    assign mag_b  = i_b[OPND_W-1] ? OPND_W'(-i_b) : OPND_W'(i_b);
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_a[OPND_W-1] ^ i_b[OPND_W-1];
                r_mc   <= WIDE_W'(mag_a);
                r_mp   <= mag_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + r_mc * WIDE_W'(r_mp[DIGIT_W-1:0]);
                r_mc  <= r_mc << DIGIT_W;
                r_mp  <= r_mp >> DIGIT_W;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rwr_div.sv
// rwr_div: restoring divider, one quotient bit a cycle, rounds half away from zero
// depends on rwr_pkg; result saturated to the signed 48-bit integer range
`default_nettype none

module rwr_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [rwr_pkg::WIDE_W-1:0] i_num,
    input  wire logic        [rwr_pkg::WIDE_W-1:0] i_den,
    output logic signed      [rwr_pkg::RESULT_W-1:0] o_quot,
    output logic                                   o_done
);
    import rwr_pkg::*;

    localparam int CW = $clog2(WIDE_W);

    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic                r_neg;
    logic [WIDE_W-1:0]   r_mag;
    logic [WIDE_W-1:0]   r_rem;
    logic [WIDE_W-1:0]   r_q;
    logic [WIDE_W-1:0]   r_den;
    logic [RESULT_W-1:0] r_quot;

    logic [WIDE_W-1:0]   shifted;
    logic                rnd;
    logic [WIDE_W:0]     qr;
    logic [RESULT_W-1:0] sat;

    assign shifted = {r_rem[WIDE_W-2:0], r_mag[WIDE_W-1]};
    assign rnd     = {r_rem, 1'b0} >= {1'b0, r_den};
    assign qr      = {1'b0, r_q} + (WIDE_W+1)'(rnd);

    always_comb begin
        if (r_neg) begin
            sat = (qr > (WIDE_W+1)'(RES_MIN)) ? RES_MIN : -qr[RESULT_W-1:0];
        end else begin
            sat = (qr > (WIDE_W+1)'(RES_MAX)) ? RES_MAX : qr[RESULT_W-1:0];
        end
    end

    assign o_quot = $signed(r_quot);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[WIDE_W-1];
                r_mag  <= i_num[WIDE_W-1] ? WIDE_W'(-i_num) : WIDE_W'(i_num);
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (shifted >= r_den) begin
                    r_rem <= shifted - r_den;
                    r_q   <= {r_q[WIDE_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q   <= {r_q[WIDE_W-2:0], 1'b0};
                end
                r_mag <= r_mag << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_quot <= sat;
                r_done <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rolling_window_regression.sv
// rolling_window_regression: top level, control sequencer, config registers
// depends on rwr_pkg, rwr_ram, rwr_acc, rwr_mul, rwr_div
//
// One result per sample. After a beat is accepted the last items_seen samples
// (at most w) are read back from the ring memory one per cycle, then the
// statistic is formed on one shared multiplier (products: none for mean, 4 for
// slope, 8 for r squared, 9 for residual) and finished by a bit-serial divider.
// Undefined results skip the divider. One item is in flight at a time; a
// finished result waits in the output register while the next beat is taken.
// The ring needs no clearing pass after reset: only entries written in the
// current series are ever read.
`default_nettype none

module rolling_window_regression #(
    parameter int WINDOW_MAX = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rwr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rwr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire rwr_pkg::t_in                     i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output rwr_pkg::t_out                         o_out_data
);
    import rwr_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_MAX - 1);
    localparam logic [31:0]   WMAX32    = 32'(WINDOW_MAX);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [3:0] ST_NSX2   = 4'd0;
    localparam logic [3:0] ST_SXSX   = 4'd1;
    localparam logic [3:0] ST_NSXY   = 4'd2;
    localparam logic [3:0] ST_SXSY   = 4'd3;
    localparam logic [3:0] ST_NSY2   = 4'd4;
    localparam logic [3:0] ST_SYSY   = 4'd5;
    localparam logic [3:0] ST_SXY2   = 4'd6;
    localparam logic [3:0] ST_SXXSYY = 4'd7;
    localparam logic [3:0] ST_NYN    = 4'd8;
    localparam logic [3:0] ST_NW     = 4'd9;
    localparam logic [3:0] ST_DSXX   = 4'd10;
    localparam logic [3:0] ST_SXYE   = 4'd11;
    localparam logic [3:0] ST_NSXX   = 4'd12;

    // configuration
    logic [1:0]             r_mode;
    logic [CNT_W-1:0]       r_wsize;
    logic [CFG_DATA_W-1:0]  r_slen;

    // sequencer and series state
    logic [2:0]             r_state;
    logic [3:0]             r_step;
    logic [AW-1:0]          r_pos;
    logic [CNT_W-1:0]       r_seen;
    logic [AW-1:0]          r_last;
    logic [CNT_W-1:0]       r_w;
    logic signed [SAMPLE_W-1:0] r_ynew;
    logic                   r_miss;
    logic                   r_acc_go;
    logic                   r_go;
    logic                   r_div_go;
    logic signed [WIDE_W-1:0] r_t;
    logic signed [OPND_W-1:0] r_sxx;
    logic signed [OPND_W-1:0] r_sxy;
    logic signed [OPND_W-1:0] r_syy;
    logic signed [OPND_W-1:0] r_d;
    logic signed [OPND_W-1:0] r_e;
    logic signed [WIDE_W-1:0] r_num;
    logic [WIDE_W-1:0]      r_den;
    logic signed [RESULT_W-1:0] r_res;
    logic                   r_def;
    logic                   r_out_valid;
    t_out                   r_out_data;

    logic [31:0]            w_c;
    logic [CNT_W-1:0]       w_eff;
    logic                   in_acc;
    logic [AW-1:0]          wr_addr;
    logic [CNT_W-1:0]       seen_base;
    logic [CNT_W-1:0]       seen_next;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [RING_W-1:0]      rd_data;
    t_sums                  sums;
    logic                   acc_done;

    logic signed [OPND_W-1:0] op_a;
    logic signed [OPND_W-1:0] op_b;
    logic signed [OPND_W-1:0] n_ext;
    logic signed [WIDE_W-1:0] mul_prod;
    logic                   mul_done;
    logic signed [WIDE_W-1:0] diff;
    logic                   diff_pos;
    logic signed [RESULT_W-1:0] div_q;
    logic                   div_done;

    always_comb begin
        w_c = {23'd0, r_wsize};
        if (w_c > WMAX32) begin
            w_c = WMAX32;
        end
        if (w_c > r_slen) begin
            w_c = r_slen;
        end
        if (w_c == 32'd0) begin
            w_c = 32'd1;
        end
    end

    assign w_eff      = w_c[CNT_W-1:0];
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_addr    = i_in_data.series_start ? '0 : r_pos;
    assign seen_base  = i_in_data.series_start ? '0 : r_seen;
    assign seen_next  = (seen_base < w_eff) ? seen_base + 1'b1 : w_eff;

    assign n_ext    = $signed(OPND_W'(sums.n));
    assign diff     = r_t - mul_prod;
    assign diff_pos = !diff[WIDE_W-1] && (diff != '0);

    always_comb begin
        case (r_step)
            ST_NSX2:   begin op_a = n_ext;               op_b = OPND_W'(sums.sx2); end
            ST_SXSX:   begin op_a = OPND_W'(sums.sx);    op_b = OPND_W'(sums.sx);  end
            ST_NSXY:   begin op_a = n_ext;               op_b = OPND_W'(sums.sxy); end
            ST_SXSY:   begin op_a = OPND_W'(sums.sx);    op_b = OPND_W'(sums.sy);  end
            ST_NSY2:   begin op_a = n_ext;               op_b = OPND_W'(sums.sy2); end
            ST_SYSY:   begin op_a = OPND_W'(sums.sy);    op_b = OPND_W'(sums.sy);  end
            ST_SXY2:   begin op_a = r_sxy;               op_b = r_sxy;             end
            ST_SXXSYY: begin op_a = r_sxx;               op_b = r_syy;             end
            ST_NYN:    begin op_a = n_ext;               op_b = OPND_W'(r_ynew);   end
            ST_NW:     begin op_a = n_ext;               op_b = $signed(OPND_W'(r_w)); end
            ST_DSXX:   begin op_a = r_d;                 op_b = r_sxx;             end
            ST_SXYE:   begin op_a = r_sxy;               op_b = r_e;               end
            ST_NSXX:   begin op_a = n_ext;               op_b = r_sxx;             end
            default:   begin op_a = '0;                  op_b = '0;                end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MEAN;
            r_wsize <= CNT_W'(1);
            r_slen  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode  <= i_cfg_data[1:0];
                CFG_WINDOW: r_wsize <= i_cfg_data[CNT_W-1:0];
                CFG_SERIES: r_slen  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_seen      <= '0;
            r_acc_go    <= 1'b0;
            r_go        <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_go <= 1'b0;
            r_go     <= 1'b0;
            r_div_go <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos    <= (wr_addr == LAST_ADDR) ? '0 : wr_addr + 1'b1;
                        r_seen   <= seen_next;
                        r_last   <= wr_addr;
                        r_w      <= w_eff;
                        r_ynew   <= i_in_data.sample;
                        r_miss   <= i_in_data.missing;
                        r_acc_go <= 1'b1;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (acc_done) begin
                        if (r_mode == MODE_MEAN) begin
                            if (sums.n != '0) begin
                                r_num    <= WIDE_W'(sums.sy) <<< 4;
                                r_den    <= WIDE_W'(sums.n);
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end else begin
                                r_res   <= '0;
                                r_def   <= 1'b0;
                                r_state <= S_OUT;
                            end
                        end else if (sums.n < CNT_W'(2)) begin
                            r_res   <= '0;
                            r_def   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_step  <= ST_NSX2;
                            r_go    <= 1'b1;
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (mul_done) begin
                        r_go <= 1'b1;
                        case (r_step)
                            ST_NSX2: begin
                                r_t    <= mul_prod;
                                r_step <= ST_SXSX;
                            end
                            ST_SXSX: begin
                                r_sxx <= OPND_W'(diff);
                                if (!diff_pos || (r_mode == MODE_RESI && r_miss)) begin
                                    r_go    <= 1'b0;
                                    r_res   <= '0;
                                    r_def   <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_step <= ST_NSXY;
                                end
                            end
                            ST_NSXY: begin
                                r_t    <= mul_prod;
                                r_step <= ST_SXSY;
                            end
                            ST_SXSY: begin
                                r_sxy <= OPND_W'(diff);
                                if (r_mode == MODE_SLOPE) begin
                                    r_go     <= 1'b0;
                                    r_num    <= diff <<< 4;
                                    r_den    <= WIDE_W'(r_sxx);
                                    r_div_go <= 1'b1;
                                    r_state  <= S_DIV;
                                end else if (r_mode == MODE_RSQ) begin
                                    r_step <= ST_NSY2;
                                end else begin
                                    r_step <= ST_NYN;
                                end
                            end
                            ST_NSY2: begin
                                r_t    <= mul_prod;
                                r_step <= ST_SYSY;
                            end
                            ST_SYSY: begin
                                r_syy <= OPND_W'(diff);
                                if (!diff_pos) begin
                                    r_go    <= 1'b0;
                                    r_res   <= '0;
                                    r_def   <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_step <= ST_SXY2;
                                end
                            end
                            ST_SXY2: begin
                                r_num  <= mul_prod <<< 16;
                                r_step <= ST_SXXSYY;
                            end
                            ST_NYN: begin
                                r_t    <= mul_prod;
                                r_step <= ST_NW;
                            end
                            ST_NW: begin
                                r_d    <= OPND_W'(r_t - WIDE_W'(sums.sy));
                                r_e    <= OPND_W'(mul_prod - WIDE_W'(sums.sx));
                                r_step <= ST_DSXX;
                            end
                            ST_DSXX: begin
                                r_num  <= mul_prod;
                                r_step <= ST_SXYE;
                            end
                            ST_SXYE: begin
                                r_num  <= r_num - mul_prod;
                                r_step <= ST_NSXX;
                            end
                            ST_SXXSYY, ST_NSXX: begin
                                if (r_step == ST_NSXX) begin
                                    r_num <= r_num <<< 4;
                                end
                                r_go     <= 1'b0;
                                r_den    <= WIDE_W'(mul_prod);
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end
                            default: begin
                                r_go    <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= div_q;
                        r_def   <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid        <= 1'b1;
                        r_out_data.result  <= r_res;
                        r_out_data.defined <= r_def;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    rwr_ram #(
        .WIDTH (RING_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (wr_addr),
        .i_wdata ({i_in_data.missing, i_in_data.sample}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rwr_acc #(
        .DEPTH (WINDOW_MAX)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_acc_go),
        .i_count   (r_seen),
        .i_w       (r_w),
        .i_last    (r_last),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_sums    (sums),
        .o_done    (acc_done)
    );

    rwr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    rwr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.defined) |-> (o_out_data.result == '0))
        else $error("undefined beat with nonzero result");

    a_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SWEEP))
        else $error("accepted beat did not start a ring sweep");

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((r_seen != '0) && (r_seen <= r_w)))
        else $error("items seen outside window");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output loaded outside the output state");

endmodule

`default_nettype wire
